// File: rtl/rhsv_pkg.sv
`timescale 1ns / 1ps

package rhsv_pkg;

    localparam int CH_W      = 8;
    localparam int HUE_W     = 15;
    localparam int SAT_W     = 16;
    localparam int HUE_Q_W   = 12;
    localparam int DIV_STEPS = 16;

    localparam logic [HUE_W-1:0] HUE_120 = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_240 = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_360 = 15'd23040;
    localparam logic [SAT_W-1:0] SAT_ONE = 16'd32768;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One restoring long division in flight: partial remainder, the numerator
    // bits not yet consumed, the quotient built so far and the divisor.
    typedef struct packed {
        logic [CH_W-1:0]      rem;
        logic [DIV_STEPS-1:0] num;
        logic [DIV_STEPS-1:0] quo;
        logic [CH_W-1:0]      den;
    } t_div;

    // A classified pixel on its way through the back end.
    typedef struct packed {
        t_div             hue_div;
        t_div             sat_div;
        logic [HUE_W-1:0] base;
        logic             neg;
        logic             grey;
        logic [CH_W-1:0]  mx;
    } t_work;

    // One quotient bit of a restoring division.
    function automatic t_div div_step(input t_div a);
        t_div         b;
        logic [CH_W:0] t;
        logic [CH_W:0] diff;
        t    = {a.rem, a.num[DIV_STEPS-1]};
        diff = t - {1'b0, a.den};
        b     = a;
        b.num = {a.num[DIV_STEPS-2:0], 1'b0};
        if (t >= {1'b0, a.den}) begin
            b.rem = diff[CH_W-1:0];
            b.quo = {a.quo[DIV_STEPS-2:0], 1'b1};
        end else begin
            b.rem = t[CH_W-1:0];
            b.quo = {a.quo[DIV_STEPS-2:0], 1'b0};
        end
        return b;
    endfunction

endpackage

// File: rtl/rhsv_front.sv
`timescale 1ns / 1ps

module rhsv_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [rhsv_pkg::CH_W-1:0] i_red,
    input  logic [rhsv_pkg::CH_W-1:0] i_green,
    input  logic [rhsv_pkg::CH_W-1:0] i_blue,
    output logic                      o_valid,
    input  logic                      i_ready,
    output rhsv_pkg::t_work           o_item
);

    logic            r_vld;
    rhsv_pkg::t_work r_item;
    rhsv_pkg::t_work n_item;

    logic                      red_max;
    logic                      green_max;
    logic [rhsv_pkg::CH_W-1:0] mx;
    logic [rhsv_pkg::CH_W-1:0] mn;
    logic [rhsv_pkg::CH_W-1:0] d;
    logic [rhsv_pkg::CH_W-1:0] mag;
    logic                      neg;
    logic [19:0]               hue_n;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        // Ties go to red first, then green.
        red_max   = (i_red >= i_green) && (i_red >= i_blue);
        green_max = !red_max && (i_green >= i_blue);
        if (red_max) begin
            mx = i_red;
        end else if (green_max) begin
            mx = i_green;
        end else begin
            mx = i_blue;
        end
        mn = i_red;
        if (i_green < mn) begin
            mn = i_green;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
        d = mx - mn;

        if (red_max) begin
            neg = i_green < i_blue;
            mag = neg ? (i_blue - i_green) : (i_green - i_blue);
        end else if (green_max) begin
            neg = i_blue < i_red;
            mag = neg ? (i_red - i_blue) : (i_blue - i_red);
        end else begin
            neg = i_red < i_green;
            mag = neg ? (i_green - i_red) : (i_red - i_green);
        end

        // 3840 * mag, the 60 degree scale in 1/64 degree units.
        hue_n = {mag, 12'b0} - {4'b0, mag, 8'b0};

        // The quotient stays below 2^12, so the top four numerator bits are
        // already smaller than the divisor and seed the remainder.
        n_item.hue_div.rem = {4'b0, hue_n[19:16]};
        n_item.hue_div.num = hue_n[15:0];
        n_item.hue_div.quo = '0;
        n_item.hue_div.den = d;

        // d * 32768 split the same way; d / 2 is below max for any max > 0.
        n_item.sat_div.rem = {1'b0, d[rhsv_pkg::CH_W-1:1]};
        n_item.sat_div.num = {d[0], 15'b0};
        n_item.sat_div.quo = '0;
        n_item.sat_div.den = mx;

        // A negative red sector wraps to 360 degrees minus the quotient.
        if (red_max) begin
            n_item.base = neg ? rhsv_pkg::HUE_360 : '0;
        end else if (green_max) begin
            n_item.base = rhsv_pkg::HUE_120;
        end else begin
            n_item.base = rhsv_pkg::HUE_240;
        end
        n_item.neg  = neg;
        n_item.grey = (d == '0);
        n_item.mx   = mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/rhsv_queue.sv
`timescale 1ns / 1ps

module rhsv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rhsv_pkg::t_work i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output rhsv_pkg::t_work o_item
);

    rhsv_pkg::t_work                   r_mem [rhsv_pkg::QDEPTH];
    logic [rhsv_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [rhsv_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [rhsv_pkg::QCNT_W-1:0]       r_count;
    logic [rhsv_pkg::QCNT_W-1:0]       n_count;
    logic                              push;
    logic                              pop;

    assign o_ready = (r_count != rhsv_pkg::QCNT_W'(rhsv_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == rhsv_pkg::QPTR_W'(rhsv_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == rhsv_pkg::QPTR_W'(rhsv_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rhsv_pkg::QCNT_W'(rhsv_pkg::QDEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers apart while empty");

endmodule

// File: rtl/rhsv_back.sv
`timescale 1ns / 1ps

module rhsv_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rhsv_pkg::t_work            i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rhsv_pkg::HUE_W-1:0] o_hue,
    output logic [rhsv_pkg::SAT_W-1:0] o_saturation,
    output logic [rhsv_pkg::CH_W-1:0]  o_brightness
);

    logic                       r_vld  [rhsv_pkg::DIV_STEPS];
    rhsv_pkg::t_work            r_stg  [rhsv_pkg::DIV_STEPS];
    rhsv_pkg::t_work            n_stg  [rhsv_pkg::DIV_STEPS];
    logic                       r_out_vld;
    logic [rhsv_pkg::HUE_W-1:0] r_hue;
    logic [rhsv_pkg::SAT_W-1:0] r_sat;
    logic [rhsv_pkg::CH_W-1:0]  r_bright;
    logic [rhsv_pkg::HUE_W-1:0] n_hue;
    logic [rhsv_pkg::SAT_W-1:0] n_sat;
    logic [rhsv_pkg::HUE_W-1:0] hue_q;
    logic                       adv;
    rhsv_pkg::t_work            last;

    // The whole divider pipeline moves together whenever the output slot frees.
    assign adv          = !r_out_vld || i_ready;
    assign o_ready      = adv;
    assign o_valid      = r_out_vld;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

    always_comb begin
        for (int k = 0; k < rhsv_pkg::DIV_STEPS; k++) begin
            if (k == 0) begin
                n_stg[k] = i_item;
            end else begin
                n_stg[k] = r_stg[k-1];
            end
            n_stg[k].hue_div = rhsv_pkg::div_step(n_stg[k].hue_div);
            n_stg[k].sat_div = rhsv_pkg::div_step(n_stg[k].sat_div);
        end
    end

    always_comb begin
        last  = r_stg[rhsv_pkg::DIV_STEPS-1];
        hue_q = {3'b0, last.hue_div.quo[rhsv_pkg::HUE_Q_W-1:0]};
        if (last.grey) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_hue = last.neg ? (last.base - hue_q) : (last.base + hue_q);
            n_sat = last.sat_div.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rhsv_pkg::DIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < rhsv_pkg::DIV_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[rhsv_pkg::DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < rhsv_pkg::DIV_STEPS; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= last.mx;
        end
    end

    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_bright == '0)) |-> (r_hue == '0 && r_sat == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_sat <= rhsv_pkg::SAT_ONE))
        else $error("saturation above one");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_hue < rhsv_pkg::HUE_360))
        else $error("hue outside one turn");

endmodule

// File: rtl/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps

// RGB to HSV converter for 8-bit pixels. Each accepted item gives exactly one
// result item carrying hue in 1/64 degree units (0 to 23039), saturation as a
// Q1.15 fraction (32768 is 1.0) and brightness, the largest channel. Red wins
// ties for the largest channel, then green; a grey or black pixel gives hue 0
// and saturation 0, and hue quotients truncate toward zero before wrapping
// into one turn. The block takes one pixel per clock and delivers one per
// clock as long as the output side keeps ready high. A result passes through
// the classifying front end register, the two-entry queue and the stages of
// the two side-by-side restoring dividers (one quotient bit per stage), after
// which it is offered from the output register. Ready on the input side falls
// only when the queue is full, which lets the front end keep accepting while
// the back end is stalled for a couple of items.

module rgb_to_hsv_pixel (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rhsv_pkg::CH_W-1:0]  i_red,
    input  logic [rhsv_pkg::CH_W-1:0]  i_green,
    input  logic [rhsv_pkg::CH_W-1:0]  i_blue,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rhsv_pkg::HUE_W-1:0] o_hue,
    output logic [rhsv_pkg::SAT_W-1:0] o_saturation,
    output logic [rhsv_pkg::CH_W-1:0]  o_brightness
);

    // Front end to queue.
    logic            fq_valid;
    logic            fq_ready;
    rhsv_pkg::t_work fq_item;

    // Queue to back end.
    logic            qb_valid;
    logic            qb_ready;
    rhsv_pkg::t_work qb_item;

    // The front end finds the largest channel, the sector, the sign and the
    // numerators for both divisions.
    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_item  (fq_item)
    );

    // A short queue lets the front end run on while the back end stalls.
    rhsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    // The back end runs both divisions and applies the sector offset.
    rhsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (qb_valid),
        .o_ready      (qb_ready),
        .i_item       (qb_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

endmodule
